/* rtl/sab_pkg.sv */
// Package for the slotted ALOHA backoff engine: widths, constants, register
// indexes, control types and the remainder step function.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package sab_pkg;

  localparam int NUM_NODES     = 8;
  localparam int MASK_W        = 8;
  localparam int COUNT_W       = 4;
  localparam int WINNER_W      = 3;
  localparam int KMAX_W        = 4;
  localparam int WAIT_W        = 5;
  localparam int RETRY_W       = 4;
  localparam int DRAW_W        = 8;
  localparam int DRAWS_W       = 64;
  localparam int TOTAL_W       = 32;
  localparam int BITS_PER_STEP = 2;
  localparam int DIV_STEPS     = DRAW_W / BITS_PER_STEP;
  localparam int STEP_CNT_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam logic [MASK_W-1:0] NODE_MASK = MASK_W'((1 << NUM_NODES) - 1);

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [CFG_IDX_W-1:0] REG_K_MAX = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PMASK = CFG_IDX_W'(1);

  localparam logic [KMAX_W-1:0] K_MAX_RST = KMAX_W'(4);
  localparam logic [MASK_W-1:0] PMASK_RST = MASK_W'(8'hFF);

  typedef struct packed {
    logic [KMAX_W-1:0] k_max;
    logic [MASK_W-1:0] participant_mask;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  // One restoring step of an unsigned remainder: shift in one dividend bit.
  function automatic logic [KMAX_W-1:0] mod_step(input logic [KMAX_W-1:0] rem,
                                                 input logic dbit,
                                                 input logic [KMAX_W-1:0] k);
    logic [KMAX_W:0] t;
    t = {rem, dbit};
    if (t >= {1'b0, k}) begin
      t = t - {1'b0, k};
    end
    return t[KMAX_W-1:0];
  endfunction

endpackage

/* rtl/sab_in_if.sv */
// Input channel of the backoff engine: one slot item per handshake.
// Depends on sab_pkg for the field widths.
`timescale 1ns / 1ps

interface sab_in_if;
  import sab_pkg::*;

  logic               valid;
  logic               ready;
  logic [MASK_W-1:0]  attempt_mask;
  logic [DRAWS_W-1:0] backoff_draws;

  modport source (output valid, attempt_mask, backoff_draws, input ready);
  modport sink (input valid, attempt_mask, backoff_draws, output ready);
endinterface

/* rtl/sab_out_if.sv */
// Result channel of the backoff engine: one slot result per handshake.
// Depends on sab_pkg for the field widths.
`timescale 1ns / 1ps

interface sab_out_if;
  import sab_pkg::*;

  logic                valid;
  logic                ready;
  logic [MASK_W-1:0]   sent_mask;
  logic [COUNT_W-1:0]  attempt_count;
  logic                collision;
  logic                success;
  logic [WINNER_W-1:0] winner_node;
  logic [MASK_W-1:0]   aborted_mask;
  logic [TOTAL_W-1:0]  total_attempts;
  logic [TOTAL_W-1:0]  total_successes;

  modport source (output valid, sent_mask, attempt_count, collision, success, winner_node,
                  aborted_mask, total_attempts, total_successes, input ready);
  modport sink (input valid, sent_mask, attempt_count, collision, success, winner_node,
                aborted_mask, total_attempts, total_successes, output ready);
endinterface

/* rtl/sab_regs.sv */
// Configuration registers of the backoff engine behind an APB-style port.
// Depends on sab_pkg for the register indexes and the cfg_t type.
`timescale 1ns / 1ps

module sab_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [sab_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [sab_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [sab_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready,
  output sab_pkg::cfg_t                  cfg
);
  import sab_pkg::*;

  logic [KMAX_W-1:0]    k_max_r;
  logic [MASK_W-1:0]    pmask_r;
  logic [CFG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx        = cfg_paddr[CFG_ADDR_W-1:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_max_r <= K_MAX_RST;
      pmask_r <= PMASK_RST;
    end else if (wr_en) begin
      case (idx)
        REG_K_MAX: k_max_r <= cfg_pwdata[KMAX_W-1:0];
        REG_PMASK: pmask_r <= cfg_pwdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_K_MAX: cfg_prdata = CFG_DATA_W'(k_max_r);
      REG_PMASK: cfg_prdata = CFG_DATA_W'(pmask_r);
      default:   cfg_prdata = '0;
    endcase
  end

  assign cfg.k_max            = k_max_r;
  assign cfg.participant_mask = pmask_r;
endmodule

/* rtl/sab_ctrl.sv */
// Controller of the backoff engine: sequences load, remainder steps and commit,
// and owns the result valid flag. Depends on sab_pkg for cmd_t.
`timescale 1ns / 1ps

module sab_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  output sab_pkg::cmd_t cmd
);
  import sab_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_COMMIT} state_t;

  state_t                state_r;
  logic [STEP_CNT_W-1:0] step_cnt_r;
  logic                  out_valid_r;

  assign in_ready   = (state_r == ST_IDLE);
  assign cmd.load   = (state_r == ST_IDLE) && in_valid;
  assign cmd.step   = (state_r == ST_DIVIDE);
  assign cmd.commit = (state_r == ST_COMMIT) && (!out_valid_r || out_ready);
  assign out_valid  = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r    <= ST_DIVIDE;
            step_cnt_r <= '0;
          end
        end
        ST_DIVIDE: begin
          step_cnt_r <= step_cnt_r + STEP_CNT_W'(1);
          if (step_cnt_r == STEP_CNT_W'(DIV_STEPS - 1)) begin
            state_r <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (!out_valid_r || out_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end
endmodule

/* rtl/sab_dp.sv */
// Datapath of the backoff engine: per-node wait and retry state, remainder
// lanes, saturating totals and the result register. Depends on sab_pkg.
`timescale 1ns / 1ps

module sab_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sab_pkg::cmd_t                cmd,
  input  sab_pkg::cfg_t                cfg,
  input  logic [sab_pkg::MASK_W-1:0]   attempt_mask,
  input  logic [sab_pkg::DRAWS_W-1:0]  backoff_draws,
  output logic [sab_pkg::MASK_W-1:0]   sent_mask,
  output logic [sab_pkg::COUNT_W-1:0]  attempt_count,
  output logic                         collision,
  output logic                         success,
  output logic [sab_pkg::WINNER_W-1:0] winner_node,
  output logic [sab_pkg::MASK_W-1:0]   aborted_mask,
  output logic [sab_pkg::TOTAL_W-1:0]  total_attempts,
  output logic [sab_pkg::TOTAL_W-1:0]  total_successes
);
  import sab_pkg::*;

  logic [WAIT_W-1:0]  wait_r [NUM_NODES];
  logic [WAIT_W-1:0]  wait_nxt [NUM_NODES];
  logic [WAIT_W-1:0]  wait_dec [NUM_NODES];
  logic [RETRY_W-1:0] retry_r [NUM_NODES];
  logic [RETRY_W-1:0] retry_nxt [NUM_NODES];
  logic [DRAW_W-1:0]  dvd_r [NUM_NODES];
  logic [DRAW_W-1:0]  dvd_nxt [NUM_NODES];
  logic [KMAX_W-1:0]  rem_r [NUM_NODES];
  logic [KMAX_W-1:0]  rem_nxt [NUM_NODES];
  logic [MASK_W-1:0]  sent_r, sent_nxt;
  logic [TOTAL_W-1:0] att_total_r, att_total_nxt;
  logic [TOTAL_W-1:0] suc_total_r, suc_total_nxt;
  logic [TOTAL_W:0]   att_sum;
  logic [COUNT_W-1:0] count_nxt;
  logic [WINNER_W-1:0] winner_nxt;
  logic [MASK_W-1:0]  aborted_nxt;
  logic [RETRY_W:0]   retry_inc;

  logic [MASK_W-1:0]   res_sent_r;
  logic [COUNT_W-1:0]  res_count_r;
  logic [WINNER_W-1:0] res_winner_r;
  logic [MASK_W-1:0]   res_aborted_r;

  always_comb begin
    count_nxt = '0;
    for (int i = 0; i < NUM_NODES; i++) begin
      count_nxt = count_nxt + COUNT_W'(sent_r[i]);
    end
  end

  always_comb begin
    sent_nxt    = sent_r;
    winner_nxt  = '0;
    aborted_nxt = '0;
    retry_inc   = '0;
    for (int i = 0; i < NUM_NODES; i++) begin
      wait_nxt[i]  = wait_r[i];
      retry_nxt[i] = retry_r[i];
      dvd_nxt[i]   = dvd_r[i];
      rem_nxt[i]   = rem_r[i];
      wait_dec[i]  = wait_r[i];
      if (cfg.participant_mask[i] && (wait_r[i] != '0)) begin
        wait_dec[i] = wait_r[i] - WAIT_W'(1);
      end
    end

    if (cmd.load) begin
      sent_nxt = '0;
      for (int i = 0; i < NUM_NODES; i++) begin
        wait_nxt[i] = wait_dec[i];
        sent_nxt[i] = cfg.participant_mask[i] && (wait_dec[i] == '0) && attempt_mask[i];
        dvd_nxt[i]  = backoff_draws[DRAW_W*i +: DRAW_W];
        rem_nxt[i]  = '0;
      end
    end

    if (cmd.step) begin
      for (int i = 0; i < NUM_NODES; i++) begin
        for (int b = 0; b < BITS_PER_STEP; b++) begin
          rem_nxt[i] = mod_step(rem_nxt[i], dvd_nxt[i][DRAW_W-1], cfg.k_max);
          dvd_nxt[i] = {dvd_nxt[i][DRAW_W-2:0], 1'b0};
        end
      end
    end

    if (cmd.commit) begin
      for (int i = 0; i < NUM_NODES; i++) begin
        retry_inc = {1'b0, retry_r[i]} + (RETRY_W+1)'(1);
        if (sent_r[i] && (count_nxt == COUNT_W'(1))) begin
          winner_nxt   = WINNER_W'(i);
          wait_nxt[i]  = '0;
          retry_nxt[i] = '0;
        end else if (sent_r[i] && (count_nxt > COUNT_W'(1))) begin
          if ((retry_inc > (RETRY_W+1)'(cfg.k_max)) || (cfg.k_max == '0)) begin
            aborted_nxt[i] = 1'b1;
            wait_nxt[i]    = '0;
            retry_nxt[i]   = '0;
          end else begin
            retry_nxt[i] = retry_inc[RETRY_W-1:0];
            wait_nxt[i]  = WAIT_W'(rem_r[i]) + WAIT_W'(2);
          end
        end
      end
    end
  end

  always_comb begin
    att_sum       = {1'b0, att_total_r} + (TOTAL_W+1)'(count_nxt);
    att_total_nxt = att_total_r;
    suc_total_nxt = suc_total_r;
    if (cmd.commit) begin
      att_total_nxt = att_sum[TOTAL_W] ? '1 : att_sum[TOTAL_W-1:0];
      if ((count_nxt == COUNT_W'(1)) && (suc_total_r != '1)) begin
        suc_total_nxt = suc_total_r + TOTAL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_NODES; i++) begin
        wait_r[i]  <= '0;
        retry_r[i] <= '0;
      end
      att_total_r <= '0;
      suc_total_r <= '0;
    end else begin
      for (int i = 0; i < NUM_NODES; i++) begin
        wait_r[i]  <= wait_nxt[i];
        retry_r[i] <= retry_nxt[i];
      end
      att_total_r <= att_total_nxt;
      suc_total_r <= suc_total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sent_r <= sent_nxt & NODE_MASK;
    for (int i = 0; i < NUM_NODES; i++) begin
      dvd_r[i] <= dvd_nxt[i];
      rem_r[i] <= rem_nxt[i];
    end
    if (cmd.commit) begin
      res_sent_r    <= sent_r;
      res_count_r   <= count_nxt;
      res_winner_r  <= winner_nxt;
      res_aborted_r <= aborted_nxt;
    end
  end

  assign sent_mask       = res_sent_r;
  assign attempt_count   = res_count_r;
  assign collision       = (res_count_r > COUNT_W'(1));
  assign success         = (res_count_r == COUNT_W'(1));
  assign winner_node     = res_winner_r;
  assign aborted_mask    = res_aborted_r;
  assign total_attempts  = att_total_r;
  assign total_successes = suc_total_r;
endmodule

/* rtl/slotted_aloha_backoff.sv */
// Slotted ALOHA contention engine with random backoff for up to eight nodes.
// One slot item is taken at a time: after the load, the per-node remainder lanes
// work through the draws 2 draw bits per step, then the commit registers the result,
// and it waits while a previous result is still held and out_ready is low.
// Reset clears all wait and retry counters and both totals; k_max reads 4 and
// participant_mask reads 255. Depends on sab_pkg, the interfaces and submodules.
`timescale 1ns / 1ps

module slotted_aloha_backoff (
  input  logic                           clk,
  input  logic                           rst_n,
  sab_in_if.sink                         in_chan,
  sab_out_if.source                      out_chan,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [sab_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [sab_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [sab_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import sab_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  sab_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  sab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .cmd       (cmd)
  );

  sab_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg             (cfg),
    .attempt_mask    (in_chan.attempt_mask),
    .backoff_draws   (in_chan.backoff_draws),
    .sent_mask       (out_chan.sent_mask),
    .attempt_count   (out_chan.attempt_count),
    .collision       (out_chan.collision),
    .success         (out_chan.success),
    .winner_node     (out_chan.winner_node),
    .aborted_mask    (out_chan.aborted_mask),
    .total_attempts  (out_chan.total_attempts),
    .total_successes (out_chan.total_successes)
  );

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("item accepted while the previous one is still in progress");

  a_count_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> ($countones(out_chan.sent_mask) == int'(out_chan.attempt_count)))
    else $error("attempt count disagrees with the sent mask");

  a_winner_is_sender: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.success) |->
      (out_chan.sent_mask == (MASK_W'(1) << out_chan.winner_node)))
    else $error("winner node is not the single sender");

  a_abort_only_on_collision: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (((out_chan.aborted_mask & ~out_chan.sent_mask) == '0) &&
                        (out_chan.collision || (out_chan.aborted_mask == '0))))
    else $error("aborted node outside a collision");
endmodule
